### hdl/kced_pkg.sv
// Shared types and constants of the key click event detector.
`default_nettype none
package kced_pkg;

    // Keys that have a raw level bit and a polarity bit; later keys read level 0, active low.
    localparam int unsigned RAW_KEYS = 4;

    localparam int unsigned CD_W   = 16;
    localparam int unsigned FLAG_W = 7;
    localparam int unsigned DIV_W  = 8;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Item commands.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH  = 3'd4;

    // Register reset values.
    localparam logic [CD_W-1:0]     RST_LONG_PRESS  = 16'd2000;
    localparam logic [CD_W-1:0]     RST_DOUBLE_WIN  = 16'd200;
    localparam logic [CD_W-1:0]     RST_REPEAT      = 16'd100;
    localparam logic [DIV_W-1:0]    RST_SAMPLE_DIV  = 8'd20;
    localparam logic [RAW_KEYS-1:0] RST_ACTIVE_HIGH = 4'd4;

    // Flag bit positions.
    localparam logic [FLAG_W-1:0] FLAG_HOLD   = 7'h01;
    localparam logic [FLAG_W-1:0] FLAG_DOWN   = 7'h02;
    localparam logic [FLAG_W-1:0] FLAG_UP     = 7'h04;
    localparam logic [FLAG_W-1:0] FLAG_SINGLE = 7'h08;
    localparam logic [FLAG_W-1:0] FLAG_DOUBLE = 7'h10;
    localparam logic [FLAG_W-1:0] FLAG_LONG   = 7'h20;
    localparam logic [FLAG_W-1:0] FLAG_REPEAT = 7'h40;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_DOUBLE   = 3'd3,
        PH_LONG     = 3'd4
    } t_phase;

    // One memory word per key.
    typedef struct packed {
        logic              pressed;
        t_phase            phase;
        logic [CD_W-1:0]   countdown;
        logic [FLAG_W-1:0] flags;
    } t_key_state;

endpackage
`default_nettype wire

### hdl/key_click_event_detector_top.sv
// Top level of the key click event detector: sequencer over the per-key state memory.
// A tick visits every key in turn, a check visits only the checked key if it exists; a new
// item is taken only once the result of the last one is in the output register. The per-key
// state memory is visited one key per cycle, read then written back in the next cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) restores the register defaults, clears the prescaler
// and marks every key's memory word invalid, so it reads as all zero until written.
`default_nettype none
module key_click_event_detector_top #(
    parameter int unsigned NUM_KEYS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Item input.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_cmd,
    input  wire logic [kced_pkg::RAW_KEYS-1:0]     i_raw_levels,
    input  wire logic [kced_pkg::IDX_W-1:0]        i_key_index,
    input  wire logic [kced_pkg::FLAG_W-1:0]       i_flag_mask,
    // Result output.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_check_hit,
    output logic      [kced_pkg::FLAG_W-1:0]       o_key_flags,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kced_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kced_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int unsigned SW = $bits(kced_pkg::t_key_state);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_WAIT,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [kced_pkg::CD_W-1:0]     r_long_ticks;
    logic [kced_pkg::CD_W-1:0]     r_double_ticks;
    logic [kced_pkg::CD_W-1:0]     r_repeat_ticks;
    logic [kced_pkg::DIV_W-1:0]    r_sample_div;
    logic [kced_pkg::RAW_KEYS-1:0] r_active_high;

    logic [kced_pkg::DIV_W-1:0]    r_prescale;

    // The accepted item.
    logic                          r_cmd;
    logic [kced_pkg::RAW_KEYS-1:0] r_levels;
    logic [kced_pkg::IDX_W-1:0]    r_idx;
    logic [kced_pkg::FLAG_W-1:0]   r_mask;
    logic                          r_sample;

    // Sweep and read-modify-write control.
    logic [KW-1:0]       r_key;
    logic                r_rd_vld;
    logic [KW-1:0]       r_rd_key;
    logic [NUM_KEYS-1:0] r_vld;

    logic                        r_res_hit;
    logic [kced_pkg::FLAG_W-1:0] r_res_flags;

    logic                        in_accept;
    logic                        rd_issue;
    logic [KW-1:0]               rd_addr;
    logic [SW-1:0]               rd_data;
    logic                        idx_ok;
    logic [kced_pkg::DIV_W-1:0]  n_prescale;
    logic                        tick_samples;
    logic                        out_free;

    kced_pkg::t_key_state        cur_entry;
    kced_pkg::t_key_state        n_entry;
    logic                        n_hit;
    logic                        cur_pressed;

    logic [NUM_KEYS-1:0]         lvl_vec;
    logic [NUM_KEYS-1:0]         pol_vec;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign idx_ok      = (int'(i_key_index) < int'(NUM_KEYS));

    assign n_prescale   = r_prescale + 1'b1;
    assign tick_samples = (n_prescale >= r_sample_div);

    // A read goes out on the accepting edge (key 0, or the checked key if it exists) and then
    // once per cycle of the tick sweep.
    always_comb begin
        rd_issue = 1'b0;
        rd_addr  = r_key;
        if (in_accept) begin
            rd_issue = (i_cmd == kced_pkg::CMD_TICK) || idx_ok;
            rd_addr  = (i_cmd == kced_pkg::CMD_TICK) ? '0 : KW'(i_key_index);
        end else if (r_state == S_TICK) begin
            rd_issue = 1'b1;
        end
    end

    kced_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_rd_vld),
        .i_waddr (r_rd_key),
        .i_wdata (n_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++) begin : g_key_bits
            if (g < kced_pkg::RAW_KEYS) begin : g_raw
                assign lvl_vec[g] = r_levels[g];
                assign pol_vec[g] = r_active_high[g];
            end else begin : g_none
                assign lvl_vec[g] = 1'b0;
                assign pol_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign cur_entry   = r_vld[r_rd_key] ? kced_pkg::t_key_state'(rd_data) : '0;
    assign cur_pressed = pol_vec[r_rd_key] ? lvl_vec[r_rd_key] : !lvl_vec[r_rd_key];

    // Modify step of the read-modify-write: timer, sampling and phase machine, or a check.
    always_comb begin
        n_entry = cur_entry;
        n_hit   = 1'b0;
        if (r_cmd == kced_pkg::CMD_TICK) begin
            if (n_entry.countdown != '0) begin
                n_entry.countdown = n_entry.countdown - 1'b1;
            end
            if (r_sample) begin
                n_entry.pressed = cur_pressed;
                if (cur_pressed) begin
                    n_entry.flags = n_entry.flags | kced_pkg::FLAG_HOLD;
                end else begin
                    n_entry.flags = n_entry.flags & ~kced_pkg::FLAG_HOLD;
                end
                if (cur_pressed && !cur_entry.pressed) begin
                    n_entry.flags = n_entry.flags | kced_pkg::FLAG_DOWN;
                end
                if (!cur_pressed && cur_entry.pressed) begin
                    n_entry.flags = n_entry.flags | kced_pkg::FLAG_UP;
                end
                unique case (cur_entry.phase)
                    kced_pkg::PH_IDLE: begin
                        if (cur_pressed) begin
                            n_entry.countdown = r_long_ticks;
                            n_entry.phase     = kced_pkg::PH_PRESSED;
                        end
                    end
                    kced_pkg::PH_PRESSED: begin
                        if (!cur_pressed) begin
                            n_entry.countdown = r_double_ticks;
                            n_entry.phase     = kced_pkg::PH_RELEASED;
                        end else if (n_entry.countdown == '0) begin
                            n_entry.countdown = r_repeat_ticks;
                            n_entry.flags     = n_entry.flags | kced_pkg::FLAG_LONG;
                            n_entry.phase     = kced_pkg::PH_LONG;
                        end
                    end
                    kced_pkg::PH_RELEASED: begin
                        if (cur_pressed) begin
                            n_entry.flags = n_entry.flags | kced_pkg::FLAG_DOUBLE;
                            n_entry.phase = kced_pkg::PH_DOUBLE;
                        end else if (n_entry.countdown == '0) begin
                            n_entry.flags = n_entry.flags | kced_pkg::FLAG_SINGLE;
                            n_entry.phase = kced_pkg::PH_IDLE;
                        end
                    end
                    kced_pkg::PH_DOUBLE: begin
                        if (!cur_pressed) begin
                            n_entry.phase = kced_pkg::PH_IDLE;
                        end
                    end
                    kced_pkg::PH_LONG: begin
                        if (!cur_pressed) begin
                            n_entry.phase = kced_pkg::PH_IDLE;
                        end else if (n_entry.countdown == '0) begin
                            n_entry.countdown = r_repeat_ticks;
                            n_entry.flags     = n_entry.flags | kced_pkg::FLAG_REPEAT;
                        end
                    end
                    default: begin
                        n_entry.phase = kced_pkg::PH_IDLE;
                    end
                endcase
            end
        end else begin
            n_hit = |(cur_entry.flags & r_mask);
            // A test of the hold bit on its own leaves the flags as they are.
            if (n_hit && (r_mask != kced_pkg::FLAG_HOLD)) begin
                n_entry.flags = cur_entry.flags & ~r_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_long_ticks   <= kced_pkg::RST_LONG_PRESS;
            r_double_ticks <= kced_pkg::RST_DOUBLE_WIN;
            r_repeat_ticks <= kced_pkg::RST_REPEAT;
            r_sample_div   <= kced_pkg::RST_SAMPLE_DIV;
            r_active_high  <= kced_pkg::RST_ACTIVE_HIGH;
            r_prescale     <= '0;
            r_key          <= '0;
            r_rd_vld       <= 1'b0;
            r_vld          <= '0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    kced_pkg::CFG_LONG_PRESS:  r_long_ticks   <= i_cfg_data;
                    kced_pkg::CFG_DOUBLE_WIN:  r_double_ticks <= i_cfg_data;
                    kced_pkg::CFG_REPEAT:      r_repeat_ticks <= i_cfg_data;
                    kced_pkg::CFG_SAMPLE_DIV:  r_sample_div   <= i_cfg_data[kced_pkg::DIV_W-1:0];
                    kced_pkg::CFG_ACTIVE_HIGH: begin
                        r_active_high <= i_cfg_data[kced_pkg::RAW_KEYS-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            r_rd_vld <= rd_issue;
            if (rd_issue) begin
                r_rd_key <= rd_addr;
            end

            if (r_rd_vld) begin
                r_vld[r_rd_key] <= 1'b1;
                if (int'(r_rd_key) == int'(r_idx)) begin
                    r_res_flags <= n_entry.flags;
                    r_res_hit   <= n_hit;
                end
            end

            // The completion state loads the next beat itself.
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd       <= i_cmd;
                        r_levels    <= i_raw_levels;
                        r_idx       <= i_key_index;
                        r_mask      <= i_flag_mask;
                        r_res_hit   <= 1'b0;
                        r_res_flags <= '0;
                        r_sample    <= (i_cmd == kced_pkg::CMD_TICK) && tick_samples;
                        if (i_cmd == kced_pkg::CMD_TICK) begin
                            r_prescale <= tick_samples ? '0 : n_prescale;
                            r_key      <= KW'(1);
                            r_state    <= (NUM_KEYS > 1) ? S_TICK : S_WAIT;
                        end else begin
                            r_state <= idx_ok ? S_WAIT : S_DONE;
                        end
                    end
                end
                S_TICK: begin
                    if (r_key == KW'(NUM_KEYS - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_key <= r_key + 1'b1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_check_hit <= r_res_hit;
                        o_key_flags <= r_res_flags;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The write-back of one key never meets a read of the same key in the sweep.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && rd_issue) |-> (rd_addr != r_rd_key))
        else $error("read and write-back hit the same key");

    // An accepted item holds off the next one until its result is in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("item accepted while another is in flight");

    // A new result beat only appears from the completion state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

    // A check of a key that does not exist reports neither a hit nor flags.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == kced_pkg::CMD_CHECK
         && int'(r_idx) >= int'(NUM_KEYS)) |-> (!r_res_hit && r_res_flags == '0))
        else $error("check of an absent key gave a result");

endmodule
`default_nettype wire

### hdl/kced_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module kced_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
